// ===== src/dtdm_pkg.sv =====
// Shared types, constants and helper functions for the departure delay block.
`default_nettype none
package dtdm_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;

   localparam int Q100_W   = 8;   // year / 100 for any 14-bit year
   localparam int YDAY_W   = 10;  // day of year, 0..364 plus slack
   localparam int HM_W     = 11;  // minute of day
   localparam int DAYS_W   = 23;  // days since the epoch
   localparam int MIN_W    = 33;  // minutes since the epoch
   localparam int PROD_W   = 27;  // year times reciprocal of 100

   localparam int EPOCH_YEAR         = 1970;
   localparam int LEAPS_BEFORE_EPOCH = 477;  // leap years in 1..1969
   localparam int DAYS_PER_YEAR      = 365;
   localparam int MIN_PER_DAY        = 1440;
   localparam int MIN_PER_HOUR       = 60;
   localparam int RECIP_100          = 5243; // 2^19 / 100, rounded up
   localparam int RECIP_SHIFT        = 19;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
   localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
   } stamp_type;

   // Classified word handed from front to back
   typedef struct packed {
      logic      ok;
      stamp_type sched;
      stamp_type act;
   } item_type;

   function automatic logic stamp_ok(input stamp_type s);
      return (s.month >= MONTH_JAN) && (s.month <= MONTH_DEC) &&
             (s.day != '0) && (s.hour <= HOUR_W'(23)) && (s.minute <= MINUTE_W'(59));
   endfunction

   // Exact floor(y / 100) for every 14-bit y
   function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] y);
      logic [PROD_W-1:0] p;
      p = PROD_W'(y) * PROD_W'(RECIP_100);
      return p[PROD_W-1 -: Q100_W];
   endfunction

   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [8:0] d;
      case (m)
         MONTH_FEB: d = 9'd31;
         MONTH_MAR: d = 9'd59;
         MONTH_APR: d = 9'd90;
         MONTH_MAY: d = 9'd120;
         MONTH_JUN: d = 9'd151;
         MONTH_JUL: d = 9'd181;
         MONTH_AUG: d = 9'd212;
         MONTH_SEP: d = 9'd243;
         MONTH_OCT: d = 9'd273;
         MONTH_NOV: d = 9'd304;
         MONTH_DEC: d = 9'd334;
         default:   d = 9'd0;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

// ===== src/dtdm_req_if.sv =====
// Request channel: scheduled and actual date-time fields.
`default_nettype none
interface dtdm_req_if;
   logic                              valid;
   logic                              ready;
   logic [dtdm_pkg::YEAR_W-1:0]       sched_year;
   logic [dtdm_pkg::MONTH_W-1:0]      sched_month;
   logic [dtdm_pkg::DAY_W-1:0]        sched_day;
   logic [dtdm_pkg::HOUR_W-1:0]       sched_hour;
   logic [dtdm_pkg::MINUTE_W-1:0]     sched_minute;
   logic [dtdm_pkg::YEAR_W-1:0]       act_year;
   logic [dtdm_pkg::MONTH_W-1:0]      act_month;
   logic [dtdm_pkg::DAY_W-1:0]        act_day;
   logic [dtdm_pkg::HOUR_W-1:0]       act_hour;
   logic [dtdm_pkg::MINUTE_W-1:0]     act_minute;

   modport source (output valid, sched_year, sched_month, sched_day, sched_hour,
                   sched_minute, act_year, act_month, act_day, act_hour, act_minute,
                   input ready);
   modport sink   (input valid, sched_year, sched_month, sched_day, sched_hour,
                   sched_minute, act_year, act_month, act_day, act_hour, act_minute,
                   output ready);
endinterface
`default_nettype wire

// ===== src/dtdm_rsp_if.sv =====
// Response channel: validity, late flag and delay.
`default_nettype none
interface dtdm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           both_valid;
   logic                           is_late;
   logic [dtdm_pkg::MIN_W-1:0]     delay_minutes;

   modport source (output valid, both_valid, is_late, delay_minutes, input ready);
   modport sink   (input valid, both_valid, is_late, delay_minutes, output ready);
endinterface
`default_nettype wire

// ===== src/dtdm_front.sv =====
// Front stage: registers the request word and classifies both date-times.
`default_nettype none
module dtdm_front (
   input  wire logic           clock,
   input  wire logic           reset,
   dtdm_req_if.sink            req_ch,
   output dtdm_pkg::item_type  push_item,
   output logic                push_valid,
   input  wire logic           push_ready
);

   dtdm_pkg::item_type  item_ff, item_in;
   logic                valid_ff, valid_in;
   logic                accept;

   assign req_ch.ready = !valid_ff || push_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      item_in.sched.year   = req_ch.sched_year;
      item_in.sched.month  = req_ch.sched_month;
      item_in.sched.day    = req_ch.sched_day;
      item_in.sched.hour   = req_ch.sched_hour;
      item_in.sched.minute = req_ch.sched_minute;
      item_in.act.year     = req_ch.act_year;
      item_in.act.month    = req_ch.act_month;
      item_in.act.day      = req_ch.act_day;
      item_in.act.hour     = req_ch.act_hour;
      item_in.act.minute   = req_ch.act_minute;
      item_in.ok           = dtdm_pkg::stamp_ok(item_in.sched) &&
                             dtdm_pkg::stamp_ok(item_in.act);
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push_item  = item_ff;
   assign push_valid = valid_ff;

endmodule
`default_nettype wire

// ===== src/dtdm_queue.sv =====
// Short queue of classified words between front and back.
`default_nettype none
module dtdm_queue #(
   parameter int DEPTH = dtdm_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dtdm_pkg::item_type  push_item,
   input  wire logic                push_valid,
   output logic                     push_ready,
   output dtdm_pkg::item_type       pop_item,
   output logic                     pop_valid,
   input  wire logic                pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   dtdm_pkg::item_type  queue_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Occupancy never runs past the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy beyond depth");

   // A word popped at a full queue frees a slot in the next cycle unless refilled
   a_full_drain: assert property (@(posedge clock) disable iff (reset)
      (!push_ready && pop && !push_valid) |=> push_ready)
      else $error("queue stayed full after pop");

endmodule
`default_nettype wire

// ===== src/dtdm_back.sv =====
// Back pipeline: epoch minutes for both date-times, then compare and subtract.
`default_nettype none
module dtdm_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dtdm_pkg::item_type  pop_item,
   input  wire logic                pop_valid,
   output logic                     pop_ready,
   dtdm_rsp_if.source               rsp_ch
);

   localparam int YW = dtdm_pkg::YEAR_W;
   localparam int QW = dtdm_pkg::Q100_W;
   localparam int DW = dtdm_pkg::DAYS_W;
   localparam int MW = dtdm_pkg::MIN_W;
   localparam int HW = dtdm_pkg::HM_W;
   localparam int ZW = dtdm_pkg::YDAY_W;

   logic                  adv;
   dtdm_pkg::stamp_type   lane [2];

   // stage 1: year split and day-of-year base
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_ok_ff;
   logic                  s1_after_ff   [2];
   logic                  s1_past_feb_ff[2];
   logic [YW-1:0]         s1_dy_ff      [2];
   logic [YW-3:0]         s1_x4_ff      [2];
   logic [QW-1:0]         s1_q100x_ff   [2];
   logic [QW-1:0]         s1_q100y_ff   [2];
   logic [YW-1:0]         s1_year_ff    [2];
   logic [ZW-1:0]         s1_yday_ff    [2];
   logic [HW-1:0]         s1_hm_ff      [2];
   logic                  s1_after_in   [2];
   logic                  s1_past_feb_in[2];
   logic [YW-1:0]         s1_dy_in      [2];
   logic [YW-1:0]         s1_xm1        [2];
   logic [ZW-1:0]         s1_yday_in    [2];
   logic [HW-1:0]         s1_hm_in      [2];

   // stage 2: day count
   logic                  s2_valid_ff;
   logic                  s2_ok_ff;
   logic [DW-1:0]         s2_days_ff    [2];
   logic [HW-1:0]         s2_hm_ff      [2];
   logic [DW-1:0]         s2_days_in    [2];
   logic [DW-1:0]         s2_ydays      [2];
   logic                  s2_leap       [2];

   // stage 3: minute count
   logic                  s3_valid_ff;
   logic                  s3_ok_ff;
   logic [MW-1:0]         s3_min_ff     [2];
   logic [MW-1:0]         s3_min_in     [2];

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_ok_ff;
   logic                  out_late_ff, out_late_in;
   logic [MW-1:0]         out_delay_ff, out_delay_in;

   assign adv       = !out_valid_ff || rsp_ch.ready;
   assign pop_ready = adv;
   assign lane[0]   = pop_item.sched;
   assign lane[1]   = pop_item.act;

   always_comb begin
      s1_valid_in = pop_valid;
      for (int i = 0; i < 2; i++) begin
         s1_after_in[i]    = lane[i].year > YW'(dtdm_pkg::EPOCH_YEAR);
         s1_dy_in[i]       = lane[i].year - YW'(dtdm_pkg::EPOCH_YEAR);
         s1_xm1[i]         = lane[i].year - 1'b1;
         s1_past_feb_in[i] = lane[i].month > dtdm_pkg::MONTH_FEB;
         // wraps for day zero; such words are invalid and masked at the end
         s1_yday_in[i]     = ZW'(dtdm_pkg::days_before_month(lane[i].month))
                             + ZW'(lane[i].day) - 1'b1;
         s1_hm_in[i]       = HW'(lane[i].hour) * HW'(dtdm_pkg::MIN_PER_HOUR)
                             + HW'(lane[i].minute);
      end
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s2_leap[i]  = (s1_year_ff[i][1:0] == 2'b00) &&
                       ((s1_year_ff[i] != YW'(s1_q100y_ff[i]) * YW'(100)) ||
                        (s1_q100y_ff[i][1:0] == 2'b00));
         s2_ydays[i] = s1_after_ff[i] ?
                       DW'(s1_dy_ff[i]) * DW'(dtdm_pkg::DAYS_PER_YEAR)
                       + DW'(s1_x4_ff[i]) - DW'(s1_q100x_ff[i])
                       + DW'(s1_q100x_ff[i][QW-1:2])
                       - DW'(dtdm_pkg::LEAPS_BEFORE_EPOCH) : '0;
         s2_days_in[i] = s2_ydays[i] + DW'(s1_yday_ff[i])
                         + DW'(s1_past_feb_ff[i] && s2_leap[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s3_min_in[i] = MW'(s2_days_ff[i]) * MW'(dtdm_pkg::MIN_PER_DAY)
                        + MW'(s2_hm_ff[i]);
      end
   end

   always_comb begin
      out_valid_in = s3_valid_ff;
      out_late_in  = s3_ok_ff && (s3_min_ff[1] > s3_min_ff[0]);
      out_delay_in = out_late_in ? s3_min_ff[1] - s3_min_ff[0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ok_ff  <= pop_item.ok;
         s2_ok_ff  <= s1_ok_ff;
         s3_ok_ff  <= s2_ok_ff;
         out_ok_ff <= s3_ok_ff;
         out_late_ff  <= out_late_in;
         out_delay_ff <= out_delay_in;
         for (int i = 0; i < 2; i++) begin
            s1_after_ff[i]    <= s1_after_in[i];
            s1_past_feb_ff[i] <= s1_past_feb_in[i];
            s1_dy_ff[i]       <= s1_dy_in[i];
            s1_x4_ff[i]       <= s1_xm1[i][YW-1:2];
            s1_q100x_ff[i]    <= dtdm_pkg::div100(s1_xm1[i]);
            s1_q100y_ff[i]    <= dtdm_pkg::div100(lane[i].year);
            s1_year_ff[i]     <= lane[i].year;
            s1_yday_ff[i]     <= s1_yday_in[i];
            s1_hm_ff[i]       <= s1_hm_in[i];
            s2_days_ff[i]     <= s2_days_in[i];
            s2_hm_ff[i]       <= s1_hm_ff[i];
            s3_min_ff[i]      <= s3_min_in[i];
         end
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.both_valid    = out_ok_ff;
   assign rsp_ch.is_late       = out_late_ff;
   assign rsp_ch.delay_minutes = out_delay_ff;

   a_late_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_late_ff) |-> out_ok_ff)
      else $error("late flag on an invalid word");

   a_delay_matches_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_late_ff == (out_delay_ff != '0)))
      else $error("delay and late flag disagree");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |=> (out_valid_ff && $stable(out_delay_ff)))
      else $error("output word changed while stalled");

endmodule
`default_nettype wire

// ===== src/datetime_delay_minutes_top.sv =====
// Departure delay block: front classifier, word queue and arithmetic back end.
// A word passes the front register, the queue and the back pipeline on its way to the response.
// Throughput: one word per cycle; the 4-stage back pipeline advances as a whole
// whenever the output register is free or being taken.
// Reset (synchronous, active high) clears the valid flags and queue pointers;
// there is no memory to sweep, so requests are taken from the first cycle after.
`default_nettype none
module datetime_delay_minutes_top #(
   parameter int QUEUE_DEPTH = dtdm_pkg::QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   dtdm_req_if.sink       req_ch,
   dtdm_rsp_if.source     rsp_ch
);

   dtdm_pkg::item_type  push_item;
   logic                push_valid;
   logic                push_ready;
   dtdm_pkg::item_type  pop_item;
   logic                pop_valid;
   logic                pop_ready;

   dtdm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   dtdm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_item   (pop_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   dtdm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_item  (pop_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire
